// File: design/etf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_pkg
// Shared constants, item types, controller state and control/status structs
// for the escape-time fractal pixel evaluator.
// ----------------------------------------------------------------------------
package etf_pkg;

	// image geometry, both sizes are powers of two
	localparam int IMAGE_WIDTH    = 1024;
	localparam int IMAGE_HEIGHT   = 1024;
	localparam int MAX_ITER_LIMIT = 4096;

	// field widths
	localparam int PIX_W    = 10;
	localparam int COORD_W  = 32;
	localparam int ZOOM_W   = 31;
	localparam int COUNT_W  = 13;
	localparam int COLOR_W  = 24;
	localparam int CFG_IDX_W = 3;

	// fixed point
	localparam int FRAC_BITS = 28;
	localparam int PROD_W    = 2 * COORD_W;

	// color scaling
	localparam logic [COLOR_W-1:0] COLOR_MAX = '1;
	localparam int NUM_W      = COUNT_W + COLOR_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W);
	localparam int LIMIT_MIN  = 2;

	// input item
	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} etf_pixel_t;

	// result item
	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic [COUNT_W-1:0] iteration_count;
	} etf_result_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JULIA_MODE   = 3'd0,
		REG_CENTER_REAL  = 3'd1,
		REG_CENTER_IMAG  = 3'd2,
		REG_ZOOM_SCALE   = 3'd3,
		REG_JULIA_C_REAL = 3'd4,
		REG_JULIA_C_IMAG = 3'd5,
		REG_ITER_LIMIT   = 3'd6
	} etf_reg_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_INIT,
		ST_MUL,
		ST_UPD,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} etf_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic map;
		logic init;
		logic mul;
		logic upd;
		logic scale;
		logic div_step;
	} etf_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic iter_done;
	} etf_stat_t;

endpackage : etf_pkg
`default_nettype wire

// File: design/escape_time_fractal_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Mandelbrot / Julia escape-time evaluator for one pixel, Q4.28 fixed point.
// ----------------------------------------------------------------------------
// sequence: once start is taken, map, init, n escape tests (n from 1 to the
//   effective limit), color scale and divide, then done; each test is a
//   multiply and an update step through the shared complex iteration unit
// items: a new start is taken only when idle, after the previous result strobe
// reset: arst_n clears the controller to idle and loads register defaults
// the result strobe lasts one cycle and the receiver cannot stall it
module escape_time_fractal_pixel (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire etf_pkg::etf_pixel_t            pixel,
	output logic                                done,
	output etf_pkg::etf_result_t                result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [etf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import etf_pkg::*;

	etf_cmd_t  cmd;
	etf_stat_t stat;
	logic      cfg_we;

	// registers take writes at any time
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer
	etf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// arithmetic
	etf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule : escape_time_fractal_pixel
`default_nettype wire

// File: design/etf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_dp
// Datapath: configuration registers, pixel to window mapping, the z*z+c
// iteration unit and the restoring divider for the color scale.
// ----------------------------------------------------------------------------
module etf_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [etf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data,
	input  wire etf_pkg::etf_pixel_t             pixel,
	input  wire etf_pkg::etf_cmd_t               cmd,
	output etf_pkg::etf_stat_t                   stat,
	output etf_pkg::etf_result_t                 result
);
	import etf_pkg::*;

	localparam int XSH   = $clog2(IMAGE_WIDTH);
	localparam int YSH   = $clog2(IMAGE_HEIGHT);
	localparam int SPAN_W = ZOOM_W + 2;
	localparam int MAP_W = PIX_W + SPAN_W;
	localparam logic [PROD_W:0] ESC_BOUND = (PROD_W+1)'(1) << (2 * FRAC_BITS + 2);

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
		lo = -hi - PROD_W'(1);
		if (v > hi) begin
			return hi[COORD_W-1:0];
		end else if (v < lo) begin
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

	// configuration registers
	logic                       julia_mode_q;
	logic signed [COORD_W-1:0]  center_real_q;
	logic signed [COORD_W-1:0]  center_imag_q;
	logic [ZOOM_W-1:0]          zoom_q;
	logic signed [COORD_W-1:0]  julia_c_real_q;
	logic signed [COORD_W-1:0]  julia_c_imag_q;
	logic [COUNT_W-1:0]         iter_limit_q;

	// item registers
	logic [PIX_W-1:0]           px_q;
	logic [PIX_W-1:0]           py_q;
	logic [COUNT_W-1:0]         lim_q;
	logic [MAP_W-1:0]           prodx_q;
	logic [MAP_W-1:0]           prody_q;
	logic signed [COORD_W-1:0]  zr_q;
	logic signed [COORD_W-1:0]  zi_q;
	logic signed [COORD_W-1:0]  cr_q;
	logic signed [COORD_W-1:0]  ci_q;
	logic signed [PROD_W-1:0]   r2_q;
	logic signed [PROD_W-1:0]   i2_q;
	logic signed [PROD_W-1:0]   ri_q;
	logic [COUNT_W-1:0]         v_q;
	logic [NUM_W-1:0]           num_q;
	logic [COUNT_W-1:0]         den_q;
	logic [COUNT_W-1:0]         rem_q;

	// combinational terms
	logic [COUNT_W-1:0]         lim_d;
	logic [SPAN_W-1:0]          span;
	logic signed [PROD_W-1:0]   half;
	logic signed [PROD_W-1:0]   pr_sum;
	logic signed [PROD_W-1:0]   pi_sum;
	logic signed [COORD_W-1:0]  pr;
	logic signed [COORD_W-1:0]  pi;
	logic                       esc;
	logic [COUNT_W-1:0]         v_next;
	logic                       lim_hit;
	logic signed [PROD_W-1:0]   nr_sum;
	logic signed [PROD_W-1:0]   ni_sum;
	logic [COUNT_W-1:0]         num_base;
	logic [COUNT_W:0]           rem_sh;
	logic                       q_bit;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia_mode_q   <= 1'b0;
			center_real_q  <= '0;
			center_imag_q  <= '0;
			zoom_q         <= ZOOM_W'(32'h1000_0000);
			julia_c_real_q <= '0;
			julia_c_imag_q <= '0;
			iter_limit_q   <= COUNT_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_JULIA_MODE:   julia_mode_q   <= cfg_data[0];
				REG_CENTER_REAL:  center_real_q  <= cfg_data;
				REG_CENTER_IMAG:  center_imag_q  <= cfg_data;
				REG_ZOOM_SCALE:   zoom_q         <= cfg_data[ZOOM_W-1:0];
				REG_JULIA_C_REAL: julia_c_real_q <= cfg_data;
				REG_JULIA_C_IMAG: julia_c_imag_q <= cfg_data;
				REG_ITER_LIMIT:   iter_limit_q   <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective limit
	always_comb begin
		if (iter_limit_q < COUNT_W'(LIMIT_MIN)) begin
			lim_d = COUNT_W'(LIMIT_MIN);
		end else if (iter_limit_q > COUNT_W'(MAX_ITER_LIMIT)) begin
			lim_d = COUNT_W'(MAX_ITER_LIMIT);
		end else begin
			lim_d = iter_limit_q;
		end
	end

	// window mapping terms
	assign span   = {zoom_q, 2'b00};
	assign half   = $signed({{(PROD_W-ZOOM_W-1){1'b0}}, zoom_q, 1'b0});
	assign pr_sum = PROD_W'(center_real_q) - half
	                + $signed({{(PROD_W-MAP_W){1'b0}}, prodx_q >> XSH});
	assign pi_sum = PROD_W'(center_imag_q) + half
	                - $signed({{(PROD_W-MAP_W){1'b0}}, prody_q >> YSH});
	assign pr     = sat32(pr_sum);
	assign pi     = sat32(pi_sum);

	// escape test and next z
	assign esc     = ({1'b0, r2_q} + {1'b0, i2_q}) >= ESC_BOUND;
	assign v_next  = v_q + COUNT_W'(1);
	assign lim_hit = v_next >= lim_q;
	assign nr_sum  = ((r2_q - i2_q) >>> FRAC_BITS) + PROD_W'(cr_q);
	assign ni_sum  = (ri_q >>> (FRAC_BITS - 1)) + PROD_W'(ci_q);

	assign stat.iter_done = esc || lim_hit;

	// color numerator base and divider step
	assign num_base = julia_mode_q ? v_q : (v_q - COUNT_W'(1));
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign q_bit    = rem_sh >= {1'b0, den_q};

	// item datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q  <= pixel.pixel_x;
			py_q  <= pixel.pixel_y;
			lim_q <= lim_d;
		end
		if (cmd.map) begin
			prodx_q <= MAP_W'(px_q) * MAP_W'(span);
			prody_q <= MAP_W'(py_q) * MAP_W'(span);
		end
		if (cmd.init) begin
			v_q <= '0;
			if (julia_mode_q) begin
				zr_q <= pr;
				zi_q <= pi;
				cr_q <= julia_c_real_q;
				ci_q <= julia_c_imag_q;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= pr;
				ci_q <= pi;
			end
		end
		if (cmd.mul) begin
			r2_q <= zr_q * zr_q;
			i2_q <= zi_q * zi_q;
			ri_q <= zr_q * zi_q;
		end
		if (cmd.upd && !esc) begin
			v_q <= v_next;
			if (!lim_hit) begin
				zr_q <= sat32(nr_sum);
				zi_q <= sat32(ni_sum);
			end
		end
		if (cmd.scale) begin
			num_q <= NUM_W'(num_base) * NUM_W'(COLOR_MAX);
			den_q <= julia_mode_q ? lim_q : (lim_q - COUNT_W'(1));
			rem_q <= '0;
		end
		// restoring divide, one quotient bit per cycle
		if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], q_bit};
			rem_q <= q_bit ? COUNT_W'(rem_sh - {1'b0, den_q}) : rem_sh[COUNT_W-1:0];
		end
	end

	// result fields
	assign result.pixel_color     = num_q[COLOR_W-1:0];
	assign result.iteration_count = v_q;

endmodule : etf_dp
`default_nettype wire

// File: design/etf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_ctrl
// Controller: sequences mapping, the iteration loop, color scaling and the
// serial divide, and raises the result strobe.
// ----------------------------------------------------------------------------
module etf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire etf_pkg::etf_stat_t  stat,
	output etf_pkg::etf_cmd_t        cmd,
	output logic                     busy,
	output logic                     done
);
	import etf_pkg::*;

	etf_state_t           state_q;
	etf_state_t           state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 div_last;

	assign div_last = div_cnt_q == DIV_CNT_W'(NUM_W - 1);

	// state register and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCALE) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_MAP;
			ST_MAP:   state_d = ST_INIT;
			ST_INIT:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_UPD;
			ST_UPD:   state_d = stat.iter_done ? ST_SCALE : ST_MUL;
			ST_SCALE: state_d = ST_DIV;
			ST_DIV:   if (div_last) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands and status
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_MAP:   cmd.map      = 1'b1;
			ST_INIT:  cmd.init     = 1'b1;
			ST_MUL:   cmd.mul      = 1'b1;
			ST_UPD:   cmd.upd      = 1'b1;
			ST_SCALE: cmd.scale    = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_DONE:  done         = 1'b1;
			default:  busy         = 1'b1;
		endcase
	end

endmodule : etf_ctrl
`default_nettype wire

// File: design/etf_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_chk
// Port-level checks on item flow of the escape-time fractal pixel evaluator.
// ----------------------------------------------------------------------------
module etf_chk (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire etf_pkg::etf_result_t  result
);
	import etf_pkg::*;

	// a taken item keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after item taken");

	// a result only comes out of a busy block
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// busy ends only right after a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	// one strobe per item
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// count never exceeds the top limit
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.iteration_count <= COUNT_W'(MAX_ITER_LIMIT))
		else $error("iteration count beyond limit");

endmodule : etf_chk

bind escape_time_fractal_pixel etf_chk u_chk (.*);
`default_nettype wire
